/* src/y2p420_pkg.sv */
// Shared types and constants for the packed 4:2:2 to planar converter.
// No dependencies; imported by every module of the block.
package y2p420_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int STORE_DEPTH = 1024;

  localparam int COL_W  = 10;   // pair column
  localparam int ROW_W  = 11;   // row
  localparam int CFG_W  = 12;   // size registers
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Pair count cap: MAX_WIDTH/2, and no more than the line store holds
  localparam int PAIR_CAP_I = (MAX_WIDTH / 2 < STORE_DEPTH) ? MAX_WIDTH / 2 : STORE_DEPTH;
  localparam int ROW_CAP_I  = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;
  localparam logic [ROW_W:0]  PAIR_CAP = (ROW_W + 1)'(PAIR_CAP_I);
  localparam logic [CFG_W:0]  ROW_CAP  = (CFG_W + 1)'(ROW_CAP_I);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_SUBSAMPLE_420  = 2'd2,
    REG_AVERAGE_CHROMA = 2'd3
  } cfg_reg_t;

  // What happens to the chroma of one word
  typedef enum logic [1:0] {
    CH_NONE = 2'd0,   // dropped (or parked in the line store)
    CH_RAW  = 2'd1,   // passed through
    CH_AVG  = 2'd2    // averaged with the stored even-row value
  } chroma_mode_t;

  typedef struct packed {
    logic [7:0]       luma_l;
    logic [7:0]       luma_r;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] crow;
    chroma_mode_t     mode;
    logic             eof;
  } item_t;

  // Line store access for one word
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;   // Cb high byte, Cr low byte
  } store_req_t;

endpackage

/* src/yuyv_to_planar_420_converter_core.sv */
// Top level of the packed 4:2:2 to planar 4:2:0 / 4:2:2 converter.
// Depends on y2p420_pkg, y2p420_seq, y2p420_line_store and y2p420_out.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready  | one YUYV macropixel word
//  out_    | out | out_tvalid/out_tready| luma pair, position, chroma, flags
//  cfg_    | in  | cfg_valid/cfg_ready  | register index + write data
//
// One word per clock sustained while out_tready does not stall; an accepted word
// enters the middle stage together with its line store read, then the output
// register, which drives out_tvalid.
// The line store is written on even rows and read on odd rows only when
// averaging; the same entry is revisited a row later, so no forwarding is needed.
// Reset (rst_n low, synchronous) clears counters and valids, sets configuration
// to its defaults and leaves the line store uncleared. A stalled output holds
// its word while one more word can still be taken into the middle stage. cfg_ready is always high.
module yuyv_to_planar_420_converter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // cfg port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [y2p420_pkg::CFG_W-1:0]  cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] luma_left_in, [15:8] cb_in, [23:16] luma_right_in, [31:24] cr_in
  input  logic [31:0]                   in_tdata,
  // output stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] luma_left_out, [15:8] luma_right_out, [26:16] luma_row,
  // [36:27] pair_column, [44:37] cb_out, [52:45] cr_out, [63:53] chroma_row
  output logic [63:0]                   out_tdata,
  // [0] chroma_valid
  output logic                          out_tuser,
  // end_of_frame
  output logic                          out_tlast
);
  import y2p420_pkg::*;

  logic       in_accept;
  item_t      item;
  store_req_t store_req;
  logic [15:0] store_rdata;

  assign cfg_ready = 1'b1;
  assign in_accept = in_tvalid & in_tready;

  y2p420_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_sel   (cfg_reg_t'(cfg_index)),
    .cfg_wdata (cfg_data),
    .in_accept (in_accept),
    .in_word   (in_tdata),
    .item      (item),
    .store_req (store_req)
  );

  y2p420_line_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  y2p420_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .item        (item),
    .store_rdata (store_rdata),
    .in_ready    (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // Line store writes only on even rows
  a_we_even: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.we |-> !item.row[0])
    else $error("line store written on an odd row");

  // Line store reads only on odd rows, never with a write
  a_re_odd: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.re |-> (item.row[0] && !store_req.we))
    else $error("line store read on an even row or together with a write");

  // Chroma bytes are zero whenever chroma is not flagged
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[52:37] == 16'd0))
    else $error("chroma bytes set on a word without chroma");

endmodule

/* src/y2p420_line_store.sv */
// Chroma line store: 1024 x 16 single-port-style RAM with a registered read.
// Depends on y2p420_pkg.
module y2p420_line_store (
  input  logic                   clk,
  input  y2p420_pkg::store_req_t req,
  output logic [15:0]            rdata
);
  import y2p420_pkg::*;

  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/y2p420_seq.sv */
// Configuration registers and column/row counters; classifies each word
// and issues its line store access. Depends on y2p420_pkg.
module y2p420_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  y2p420_pkg::cfg_reg_t          cfg_sel,
  input  logic [y2p420_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                          in_accept,
  input  logic [31:0]                   in_word,
  output y2p420_pkg::item_t             item,
  output y2p420_pkg::store_req_t        store_req
);
  import y2p420_pkg::*;

  logic [CFG_W-1:0] width_r, height_r;
  logic             sub_r, avg_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [ROW_W-1:0] pairs;
  logic [CFG_W:0]   rows;
  logic             last_col, last_row;
  chroma_mode_t     mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(384);
      height_r <= CFG_W'(288);
      sub_r    <= 1'b1;
      avg_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:    width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT:   height_r <= cfg_wdata;
        REG_SUBSAMPLE_420:  sub_r    <= cfg_wdata[0];
        REG_AVERAGE_CHROMA: avg_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero taken as one, then capped
  always_comb begin
    pairs = width_r[CFG_W-1:1];
    if (pairs == '0) pairs = ROW_W'(1);
    if ({1'b0, pairs} > PAIR_CAP) pairs = PAIR_CAP[ROW_W-1:0];
    rows = {1'b0, height_r};
    if (rows == '0) rows = (CFG_W + 1)'(1);
    if (rows > ROW_CAP) rows = ROW_CAP;
  end

  assign last_col = ({1'b0, col_r} + ROW_W'(1)) >= pairs;
  assign last_row = ({1'b0, row_r} + (ROW_W + 1)'(1)) >= rows[ROW_W:0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    if (!sub_r)            mode = CH_RAW;
    else if (avg_r)        mode = row_r[0] ? CH_AVG : CH_NONE;
    else                   mode = row_r[0] ? CH_NONE : CH_RAW;
  end

  always_comb begin
    item.luma_l = in_word[7:0];
    item.cb     = in_word[15:8];
    item.luma_r = in_word[23:16];
    item.cr     = in_word[31:24];
    item.row    = row_r;
    item.col    = col_r;
    item.crow   = sub_r ? {1'b0, row_r[ROW_W-1:1]} : row_r;
    item.mode   = mode;
    item.eof    = last_col & last_row;
  end

  // When averaging in 4:2:0 mode, even rows park chroma and odd rows fetch it back; a full row lies between
  always_comb begin
    store_req.addr  = col_r[ADDR_W-1:0];
    store_req.wdata = {in_word[15:8], in_word[31:24]};
    store_req.we    = in_accept & sub_r & avg_r & ~row_r[0];
    store_req.re    = in_accept & (mode == CH_AVG);
  end

endmodule

/* src/y2p420_out.sv */
// Pipeline register waiting on line store data, chroma averaging and the
// output register with its stall handling. Depends on y2p420_pkg.
module y2p420_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  y2p420_pkg::item_t item,
  input  logic [15:0]       store_rdata,
  output logic              in_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import y2p420_pkg::*;

  item_t       s1_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_adv;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_user_r, out_last_r;
  logic [8:0]  cb_sum, cr_sum;
  logic [7:0]  cb_o, cr_o;
  logic        cv;

  assign s1_adv   = ~out_valid_r | out_tready;
  assign in_ready = ~s1_valid_r | s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept)   s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
    if (in_accept) s1_r <= item;
  end

  assign cb_sum = {1'b0, store_rdata[15:8]} + {1'b0, s1_r.cb};
  assign cr_sum = {1'b0, store_rdata[7:0]}  + {1'b0, s1_r.cr};

  always_comb begin
    case (s1_r.mode)
      CH_RAW: begin
        cv = 1'b1; cb_o = s1_r.cb; cr_o = s1_r.cr;
      end
      CH_AVG: begin
        cv = 1'b1; cb_o = cb_sum[8:1]; cr_o = cr_sum[8:1];
      end
      default: begin
        cv = 1'b0; cb_o = '0; cr_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s1_adv) out_valid_r <= s1_valid_r;
    if (s1_adv) begin
      out_data_r <= {s1_r.crow, cr_o, cb_o, s1_r.col, s1_r.row, s1_r.luma_r, s1_r.luma_l};
      out_user_r <= cv;
      out_last_r <= s1_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
